>>> design/point_deque_nearest_farthest_top_macros.svh
// Assertion macros for the point deque checker.
`ifndef POINT_DEQUE_NEAREST_FARTHEST_TOP_MACROS_SVH
`define POINT_DEQUE_NEAREST_FARTHEST_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define PDNF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define PDNF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/pdnf_pkg.sv
// Shared types, codes and constants for the point deque block.
package pdnf_pkg;

    localparam int FIELD_W        = 16;
    localparam int REQ_W          = 3;
    localparam int STAT_W         = 2;
    localparam int CNT_OUT_W      = 5;
    localparam int CAPACITY_DEF   = 16;
    localparam int COORD_BITS_DEF = 16;

    localparam logic [REQ_W-1:0] REQ_PUSH_TOP = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP_TOP  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PUSH_BOT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BOT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_COUNT    = 3'd5;
    localparam logic [REQ_W-1:0] REQ_FARTHEST = 3'd6;
    localparam logic [REQ_W-1:0] REQ_NEAREST  = 3'd7;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        SEL_X,
        SEL_Y,
        SEL_Z
    } t_coord_sel;

    typedef struct packed {
        t_coord_sel sel;
        logic       mul_en;
        logic       acc_clr;
        logic       acc_add;
    } t_sq_ctl;

endpackage

>>> design/point_deque_nearest_farthest_top.sv
// Top level of the point deque with nearest and farthest query.
// A bounded double-ended list of up to CAPACITY signed 3D points kept in a ring
// memory. One request is taken at a time: o_stall is high from acceptance until
// the result is loaded into the output register. Push, pop, clear and count go
// straight to the finish state, which loads that register once it is free.
// A farthest or nearest query uses one squaring multiplier three times per entry
// (x, y, z) and the memory has a single read port, so each entry passes through
// the MX, MY, MZ and CMP states in turn. Ties keep the entry nearest the bottom.
// The store needs no clearing after reset; only held entries are ever read.
module point_deque_nearest_farthest_top
    import pdnf_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [REQ_W-1:0]           i_req_type,
    input  logic signed [FIELD_W-1:0]  i_point_x,
    input  logic signed [FIELD_W-1:0]  i_point_y,
    input  logic signed [FIELD_W-1:0]  i_point_z,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [STAT_W-1:0]          o_status,
    output logic [CNT_OUT_W-1:0]       o_entry_count,
    output logic signed [FIELD_W-1:0]  o_found_x,
    output logic signed [FIELD_W-1:0]  o_found_y,
    output logic signed [FIELD_W-1:0]  o_found_z
);

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int DIST_W = 2 * COORD_BITS;
    localparam int MEM_W  = 3 * COORD_BITS;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [IDX_W:0]   CAP_SUM  = (IDX_W + 1)'(CAPACITY);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_MX   = 3'd2;
    localparam logic [2:0] ST_MY   = 3'd3;
    localparam logic [2:0] ST_MZ   = 3'd4;
    localparam logic [2:0] ST_CMP  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_held, n_held;
    logic [IDX_W-1:0]      r_bottom, n_bottom;
    logic [IDX_W-1:0]      r_slot, n_slot;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic                  r_far, n_far;
    logic [STAT_W-1:0]     r_status, n_status;
    logic [DIST_W-1:0]     r_best, n_best;
    logic [COORD_BITS-1:0] r_fx, n_fx;
    logic [COORD_BITS-1:0] r_fy, n_fy;
    logic [COORD_BITS-1:0] r_fz, n_fz;

    logic                      r_out_valid;
    logic [STAT_W-1:0]         r_out_status;
    logic [CNT_OUT_W-1:0]      r_out_count;
    logic [FIELD_W-1:0]        r_out_x, r_out_y, r_out_z;

    logic [COORD_BITS-1:0] w_px, w_py, w_pz;
    logic [FIELD_W-1:0]    w_ox, w_oy, w_oz;
    logic [MEM_W-1:0]      w_rdata;
    logic [DIST_W-1:0]     w_dist;
    logic [IDX_W:0]        w_top_sum;
    logic [IDX_W-1:0]      w_top_slot;
    logic [IDX_W-1:0]      w_bot_dn;
    logic [IDX_W-1:0]      w_bot_up;
    logic [IDX_W-1:0]      w_slot_nx;
    logic                  w_full, w_empty, w_take;
    logic                  w_we, w_re, w_out_load;
    logic [IDX_W-1:0]      w_waddr, w_raddr;
    t_sq_ctl               w_ctl;

    // coordinate fit: low bits taken when narrower than the port, zero-extended when wider
    if (COORD_BITS <= FIELD_W) begin : g_in_narrow
        assign w_px = i_point_x[COORD_BITS-1:0];
        assign w_py = i_point_y[COORD_BITS-1:0];
        assign w_pz = i_point_z[COORD_BITS-1:0];
    end else begin : g_in_wide
        assign w_px = COORD_BITS'($unsigned(i_point_x));
        assign w_py = COORD_BITS'($unsigned(i_point_y));
        assign w_pz = COORD_BITS'($unsigned(i_point_z));
    end

    // found point leaves as its raw COORD_BITS code, zero-filled above
    if (COORD_BITS >= FIELD_W) begin : g_out_wide
        assign w_ox = r_fx[FIELD_W-1:0];
        assign w_oy = r_fy[FIELD_W-1:0];
        assign w_oz = r_fz[FIELD_W-1:0];
    end else begin : g_out_narrow
        assign w_ox = FIELD_W'(r_fx);
        assign w_oy = FIELD_W'(r_fy);
        assign w_oz = FIELD_W'(r_fz);
    end

    assign w_full     = (r_held == CAP_CNT);
    assign w_empty    = (r_held == '0);
    assign w_top_sum  = {1'b0, r_bottom} + {1'b0, IDX_W'(r_held)};
    assign w_top_slot = (w_top_sum >= CAP_SUM) ? IDX_W'(w_top_sum - CAP_SUM)
                                               : IDX_W'(w_top_sum);
    assign w_bot_dn   = (r_bottom == '0) ? LAST_IDX : r_bottom - IDX_W'(1);
    assign w_bot_up   = (r_bottom == LAST_IDX) ? '0 : r_bottom + IDX_W'(1);
    assign w_slot_nx  = (r_slot == LAST_IDX) ? '0 : r_slot + IDX_W'(1);

    // candidate wins on first entry or on a strict improvement
    assign w_take = (r_idx == '0) || (r_far && (w_dist > r_best)) ||
                    (!r_far && (w_dist < r_best));

    always_comb begin
        n_state    = r_state;
        n_held     = r_held;
        n_bottom   = r_bottom;
        n_slot     = r_slot;
        n_idx      = r_idx;
        n_far      = r_far;
        n_status   = r_status;
        n_best     = r_best;
        n_fx       = r_fx;
        n_fy       = r_fy;
        n_fz       = r_fz;
        w_we       = 1'b0;
        w_waddr    = w_top_slot;
        w_re       = 1'b0;
        w_raddr    = r_slot;
        w_out_load = 1'b0;
        w_ctl      = '{sel: SEL_X, mul_en: 1'b0, acc_clr: 1'b0, acc_add: 1'b0};

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_status = STAT_OK;
                    n_fx     = '0;
                    n_fy     = '0;
                    n_fz     = '0;
                    n_state  = ST_FIN;
                    unique case (i_req_type)
                        REQ_PUSH_TOP: begin
                            if (w_full) begin
                                n_status = STAT_FULL;
                            end else begin
                                w_we   = 1'b1;
                                n_held = r_held + CNT_W'(1);
                            end
                        end
                        REQ_POP_TOP: begin
                            if (w_empty) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_held = r_held - CNT_W'(1);
                            end
                        end
                        REQ_PUSH_BOT: begin
                            if (w_full) begin
                                n_status = STAT_FULL;
                            end else begin
                                w_we     = 1'b1;
                                w_waddr  = w_bot_dn;
                                n_bottom = w_bot_dn;
                                n_held   = r_held + CNT_W'(1);
                            end
                        end
                        REQ_POP_BOT: begin
                            if (w_empty) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_bottom = w_bot_up;
                                n_held   = r_held - CNT_W'(1);
                            end
                        end
                        REQ_CLEAR: begin
                            n_held   = '0;
                            n_bottom = '0;
                        end
                        REQ_COUNT: begin
                        end
                        REQ_FARTHEST, REQ_NEAREST: begin
                            if (w_empty) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_slot  = r_bottom;
                                n_idx   = '0;
                                n_far   = (i_req_type == REQ_FARTHEST);
                                n_state = ST_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD: begin
                w_re    = 1'b1;
                n_state = ST_MX;
            end
            ST_MX: begin
                w_ctl   = '{sel: SEL_X, mul_en: 1'b1, acc_clr: 1'b0, acc_add: 1'b0};
                n_state = ST_MY;
            end
            ST_MY: begin
                w_ctl   = '{sel: SEL_Y, mul_en: 1'b1, acc_clr: 1'b1, acc_add: 1'b0};
                n_state = ST_MZ;
            end
            ST_MZ: begin
                w_ctl   = '{sel: SEL_Z, mul_en: 1'b1, acc_clr: 1'b0, acc_add: 1'b1};
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (w_take) begin
                    n_best = w_dist;
                    n_fx   = w_rdata[MEM_W-1:2*COORD_BITS];
                    n_fy   = w_rdata[2*COORD_BITS-1:COORD_BITS];
                    n_fz   = w_rdata[COORD_BITS-1:0];
                end
                if ((r_idx + CNT_W'(1)) == r_held) begin
                    n_state = ST_FIN;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_slot  = w_slot_nx;
                    w_re    = 1'b1;
                    w_raddr = w_slot_nx;
                    n_state = ST_MX;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_held   <= '0;
            r_bottom <= '0;
        end else begin
            r_state  <= n_state;
            r_held   <= n_held;
            r_bottom <= n_bottom;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot   <= n_slot;
        r_idx    <= n_idx;
        r_far    <= n_far;
        r_status <= n_status;
        r_best   <= n_best;
        r_fx     <= n_fx;
        r_fy     <= n_fy;
        r_fz     <= n_fz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status <= r_status;
            r_out_count  <= CNT_OUT_W'(r_held);
            r_out_x      <= w_ox;
            r_out_y      <= w_oy;
            r_out_z      <= w_oz;
        end
    end

    pdnf_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (MEM_W),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({w_px, w_py, w_pz}),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pdnf_sqacc #(
        .COORD_BITS (COORD_BITS)
    ) u_sqacc (
        .i_clk   (i_clk),
        .i_entry (w_rdata),
        .i_ctl   (w_ctl),
        .o_dist  (w_dist)
    );

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;
    assign o_found_x     = r_out_x;
    assign o_found_y     = r_out_y;
    assign o_found_z     = r_out_z;

endmodule

>>> design/pdnf_mem.sv
// Point store: one write port, one registered read port.
module pdnf_mem
    import pdnf_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int WIDTH = 3 * COORD_BITS_DEF,
    parameter int AW    = $clog2(CAPACITY_DEF)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/pdnf_sqacc.sv
// Shared squaring multiplier and accumulator for squared magnitude.
module pdnf_sqacc
    import pdnf_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic [3*COORD_BITS-1:0]   i_entry,
    input  t_sq_ctl                   i_ctl,
    output logic [2*COORD_BITS-1:0]   o_dist
);

    localparam int DIST_W = 2 * COORD_BITS;

    logic signed [COORD_BITS-1:0] w_a;
    logic signed [DIST_W-1:0]     w_sq;
    logic [DIST_W-1:0]            r_prod;
    logic [DIST_W-1:0]            r_acc;

    always_comb begin
        unique case (i_ctl.sel)
            SEL_X:   w_a = i_entry[3*COORD_BITS-1:2*COORD_BITS];
            SEL_Y:   w_a = i_entry[2*COORD_BITS-1:COORD_BITS];
            SEL_Z:   w_a = i_entry[COORD_BITS-1:0];
            default: w_a = i_entry[COORD_BITS-1:0];
        endcase
    end

    assign w_sq = w_a * w_a;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= $unsigned(w_sq);
        end
        if (i_ctl.acc_clr) begin
            r_acc <= r_prod;
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
    end

    // last product folds in here, ahead of the compare
    assign o_dist = r_acc + r_prod;

endmodule

>>> design/pdnf_checker.sv
// Port-level assertion checker for the point deque, bound to the top level.
`include "point_deque_nearest_farthest_top_macros.svh"

module pdnf_checker
    import pdnf_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [STAT_W-1:0]         o_status,
    input logic [CNT_OUT_W-1:0]      o_entry_count,
    input logic signed [FIELD_W-1:0] o_found_x,
    input logic signed [FIELD_W-1:0] o_found_y,
    input logic signed [FIELD_W-1:0] o_found_z
);

    localparam logic [CNT_OUT_W-1:0] CAP_OUT = CNT_OUT_W'(CAPACITY);

    // one request in flight at a time
    `PDNF_ASSERT_NXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "no stall after accept")

    `PDNF_ASSERT_NXT(a_out_hold, o_valid && i_stall,
        o_valid && $stable(o_status) && $stable(o_entry_count) && $stable(o_found_x),
        "stalled result beat changed")

    `PDNF_ASSERT_IMP(a_empty_result, o_valid && (o_status == STAT_EMPTY),
        (o_entry_count == '0) && (o_found_x == '0) && (o_found_y == '0) && (o_found_z == '0),
        "empty status with nonzero count or point")

    `PDNF_ASSERT_IMP(a_full_result, o_valid && (o_status == STAT_FULL),
        (o_entry_count == CAP_OUT) && (o_found_x == '0),
        "full status without full count")

endmodule

bind point_deque_nearest_farthest_top pdnf_checker #(.CAPACITY(CAPACITY)) u_pdnf_checker (.*);

>>> bench/tb_point_deque_nearest_farthest_top.sv
// Self-checking testbench for the point deque with nearest and farthest query.
module tb_point_deque_nearest_farthest_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pdnf_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int LIMIT_CYCLES = 800_000;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_REPORTS  = 50;

    typedef struct packed {
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic signed [FIELD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [CNT_OUT_W-1:0] count;
        t_point               found;
    } t_outcome;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_RUNS
    } t_stall_mode;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [REQ_W-1:0]          i_req_type = REQ_COUNT;
    logic signed [FIELD_W-1:0] i_point_x = '0;
    logic signed [FIELD_W-1:0] i_point_y = '0;
    logic signed [FIELD_W-1:0] i_point_z = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [STAT_W-1:0]         o_status;
    logic [CNT_OUT_W-1:0]      o_entry_count;
    logic signed [FIELD_W-1:0] o_found_x;
    logic signed [FIELD_W-1:0] o_found_y;
    logic signed [FIELD_W-1:0] o_found_z;

    t_point   held_points [CAP];
    int       held_bottom = 0;
    int       held_total = 0;
    t_outcome pending_results [$];
    t_outcome want;

    int burst_left = 0;
    int requests_sent = 0;
    int pushes_sent = 0;
    int pops_sent = 0;
    int queries_sent = 0;
    int full_refusals = 0;
    int empty_refusals = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    t_stall_mode stall_mode = STALL_NONE;
    int          stall_phase_left = 0;
    int          stall_run_left = 0;
    logic        stall_level = 1'b0;

    logic signed [FIELD_W-1:0] corner_vals [6] = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0,
                                                   16'sd1, 16'sh7fff};

    point_deque_nearest_farthest_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_found_x     (o_found_x),
        .o_found_y     (o_found_y),
        .o_found_z     (o_found_z)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint sq_mag(t_point p);
        longint x, y, z;
        x = $signed(p.x);
        y = $signed(p.y);
        z = $signed(p.z);
        return x * x + y * y + z * z;
    endfunction

    // Updates the held list and returns the result the request must produce.
    function automatic t_outcome predict_outcome(logic [REQ_W-1:0] req, t_point p);
        t_outcome res;
        int       best, pos;
        longint   best_d, d;
        res = '0;
        case (req)
            REQ_PUSH_TOP, REQ_PUSH_BOT: begin
                if (held_total >= CAP) begin
                    res.status = STAT_FULL;
                end else if (req == REQ_PUSH_TOP) begin
                    held_points[(held_bottom + held_total) % CAP] = p;
                    held_total++;
                end else begin
                    held_bottom = (held_bottom + CAP - 1) % CAP;
                    held_points[held_bottom] = p;
                    held_total++;
                end
            end
            REQ_POP_TOP: begin
                if (held_total == 0) res.status = STAT_EMPTY;
                else held_total--;
            end
            REQ_POP_BOT: begin
                if (held_total == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    held_bottom = (held_bottom + 1) % CAP;
                    held_total--;
                end
            end
            REQ_CLEAR: begin
                held_total = 0;
                held_bottom = 0;
            end
            REQ_COUNT: ;
            default: begin
                if (held_total == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    best = held_bottom;
                    best_d = sq_mag(held_points[best]);
                    for (int i = 1; i < held_total; i++) begin
                        pos = (held_bottom + i) % CAP;
                        d = sq_mag(held_points[pos]);
                        if ((req == REQ_FARTHEST && d > best_d) ||
                            (req == REQ_NEAREST && d < best_d)) begin
                            best = pos;
                            best_d = d;
                        end
                    end
                    res.found = held_points[best];
                end
            end
        endcase
        res.count = CNT_OUT_W'(held_total);
        return res;
    endfunction

    function automatic t_point mkpt(int x, int y, int z);
        t_point p;
        p.x = FIELD_W'(x);
        p.y = FIELD_W'(y);
        p.z = FIELD_W'(z);
        return p;
    endfunction

    function automatic logic signed [FIELD_W-1:0] rand_coord(int style);
        if (style < 5) return FIELD_W'($urandom);
        if (style < 8) return FIELD_W'($signed($urandom_range(0, 16)) - 8);
        return corner_vals[$urandom_range(0, 5)];
    endfunction

    function automatic t_point rand_point();
        t_point p;
        int     style;
        style = $urandom_range(0, 9);
        p.x = rand_coord(style);
        p.y = rand_coord(style);
        p.z = rand_coord(style);
        return p;
    endfunction

    // Same squared magnitude, coordinates permuted with random signs.
    function automatic t_point tie_point(int a, int b, int c);
        t_point p;
        case ($urandom_range(0, 5))
            0: p = mkpt(a, b, c);
            1: p = mkpt(a, c, b);
            2: p = mkpt(b, a, c);
            3: p = mkpt(b, c, a);
            4: p = mkpt(c, a, b);
            default: p = mkpt(c, b, a);
        endcase
        if ($urandom_range(0, 1) == 1) p.x = -p.x;
        if ($urandom_range(0, 1) == 1) p.y = -p.y;
        if ($urandom_range(0, 1) == 1) p.z = -p.z;
        return p;
    endfunction

    function automatic logic [REQ_W-1:0] pick_request(int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) return ($urandom_range(0, 1) == 1) ? REQ_PUSH_TOP : REQ_PUSH_BOT;
        r = $urandom_range(0, 99);
        if (r < 45) return ($urandom_range(0, 1) == 1) ? REQ_POP_TOP : REQ_POP_BOT;
        if (r < 70) return REQ_FARTHEST;
        if (r < 94) return REQ_NEAREST;
        if (r < 98) return REQ_COUNT;
        return REQ_CLEAR;
    endfunction

    task automatic send_request(logic [REQ_W-1:0] req, t_point p);
        int       gap;
        t_outcome res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_point_x  <= p.x;
        i_point_y  <= p.y;
        i_point_z  <= p.z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        res = predict_outcome(req, p);
        pending_results = {pending_results, res};
        requests_sent++;
        if (req == REQ_PUSH_TOP || req == REQ_PUSH_BOT) pushes_sent++;
        if (req == REQ_POP_TOP || req == REQ_POP_BOT) pops_sent++;
        if (req == REQ_FARTHEST || req == REQ_NEAREST) queries_sent++;
        if (res.status == STAT_FULL) full_refusals++;
        if (res.status == STAT_EMPTY) empty_refusals++;
    endtask

    task automatic report_mismatch(string what, longint got, longint exp_val);
        if (mismatch_count < MAX_REPORTS)
            $display("MISMATCH %s: got %0d, want %0d (result %0d)", what, got, exp_val,
                     results_checked);
        mismatch_count++;
    endtask

    task automatic test_empty_requests();
        send_request(REQ_POP_TOP, rand_point());
        send_request(REQ_POP_BOT, rand_point());
        send_request(REQ_FARTHEST, rand_point());
        send_request(REQ_NEAREST, rand_point());
        send_request(REQ_COUNT, rand_point());
        send_request(REQ_CLEAR, rand_point());
    endtask

    task automatic test_corner_points();
        send_request(REQ_PUSH_TOP, mkpt(32767, 32767, 32767));
        send_request(REQ_PUSH_BOT, mkpt(-32768, -32768, -32768));
        send_request(REQ_PUSH_TOP, mkpt(0, 0, 0));
        send_request(REQ_PUSH_BOT, mkpt(-1, 1, -1));
        send_request(REQ_PUSH_TOP, mkpt(1, -1, 1));
        send_request(REQ_PUSH_TOP, mkpt(0, 0, 0));
        send_request(REQ_PUSH_BOT, mkpt(-32768, 0, 32767));
        send_request(REQ_FARTHEST, mkpt(0, 0, 0));
        send_request(REQ_NEAREST, mkpt(-1, -1, -1));
        send_request(REQ_COUNT, mkpt(0, 0, 0));
        send_request(REQ_POP_BOT, mkpt(0, 0, 0));
        send_request(REQ_POP_TOP, mkpt(0, 0, 0));
        send_request(REQ_FARTHEST, mkpt(0, 0, 0));
        send_request(REQ_NEAREST, mkpt(0, 0, 0));
        send_request(REQ_CLEAR, mkpt(0, 0, 0));
        send_request(REQ_COUNT, mkpt(0, 0, 0));
    endtask

    task automatic test_fill_and_drain(int rounds);
        for (int r = 0; r < rounds; r++) begin
            while (held_total < CAP) begin
                send_request(($urandom_range(0, 1) == 1) ? REQ_PUSH_TOP : REQ_PUSH_BOT,
                             rand_point());
                if ($urandom_range(0, 5) == 0)
                    send_request(($urandom_range(0, 1) == 1) ? REQ_FARTHEST : REQ_NEAREST,
                                 rand_point());
            end
            send_request(REQ_PUSH_TOP, rand_point());
            send_request(REQ_PUSH_BOT, rand_point());
            send_request(REQ_FARTHEST, rand_point());
            send_request(REQ_NEAREST, rand_point());
            send_request(REQ_COUNT, rand_point());
            while (held_total > 0) begin
                send_request(($urandom_range(0, 1) == 1) ? REQ_POP_TOP : REQ_POP_BOT,
                             rand_point());
                if ($urandom_range(0, 3) == 0)
                    send_request(($urandom_range(0, 1) == 1) ? REQ_FARTHEST : REQ_NEAREST,
                                 rand_point());
            end
            send_request(($urandom_range(0, 1) == 1) ? REQ_POP_TOP : REQ_POP_BOT, rand_point());
            send_request(REQ_NEAREST, rand_point());
        end
    endtask

    task automatic test_tie_breaks(int groups);
        int a, b, c, n;
        for (int g = 0; g < groups; g++) begin
            send_request(REQ_CLEAR, rand_point());
            a = $urandom_range(0, 180);
            b = $urandom_range(0, 180);
            c = $urandom_range(0, 180);
            n = $urandom_range(3, 8);
            for (int i = 0; i < n; i++) begin
                send_request(($urandom_range(0, 1) == 1) ? REQ_PUSH_TOP : REQ_PUSH_BOT,
                             tie_point(a, b, c));
                if ($urandom_range(0, 3) == 0)
                    send_request(REQ_PUSH_TOP, tie_point(a + 1, b, c));
            end
            send_request(REQ_FARTHEST, rand_point());
            send_request(REQ_NEAREST, rand_point());
            send_request(REQ_POP_BOT, rand_point());
            send_request(REQ_FARTHEST, rand_point());
            send_request(REQ_NEAREST, rand_point());
        end
    endtask

    task automatic test_random_mix(int items);
        int push_pct;
        push_pct = 50;
        for (int i = 0; i < items; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 75;
                    1: push_pct = 20;
                    default: push_pct = 50;
                endcase
            end
            send_request(pick_request(push_pct), rand_point());
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_phase_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            stall_phase_left = $urandom_range(40, 300);
        end else begin
            stall_phase_left--;
        end
        case (stall_mode)
            STALL_NONE: i_stall <= 1'b0;
            STALL_COIN: i_stall <= ($urandom_range(0, 1) == 1);
            default: begin
                if (stall_run_left == 0) begin
                    stall_level = !stall_level;
                    stall_run_left = $urandom_range(1, 20);
                end
                stall_run_left--;
                i_stall <= stall_level;
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", o_status, -1);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_entry_count !== want.count)
                    report_mismatch("entry_count", o_entry_count, want.count);
                if (o_found_x !== want.found.x)
                    report_mismatch("found_x", o_found_x, $signed(want.found.x));
                if (o_found_y !== want.found.y)
                    report_mismatch("found_y", o_found_y, $signed(want.found.y));
                if (o_found_z !== want.found.z)
                    report_mismatch("found_z", o_found_z, $signed(want.found.z));
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_requests();
        test_corner_points();
        test_fill_and_drain(8);
        test_tie_breaks(12);
        test_random_mix(740);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());
        $display("Ran %0d requests: %0d pushes, %0d pops, %0d nearest/farthest queries",
                 requests_sent, pushes_sent, pops_sent, queries_sent);
        $display("Full refusals %0d, empty refusals %0d, %0d results checked, %0d mismatches",
                 full_refusals, empty_refusals, results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/pdnf_pkg.sv
design/pdnf_mem.sv
design/pdnf_sqacc.sv
design/point_deque_nearest_farthest_top.sv
design/pdnf_checker.sv
bench/tb_point_deque_nearest_farthest_top.sv
